// File: rtl/mhpq_pkg.sv
// ============================================================================
// mhpq_pkg
// Shared types and constants for the min-heap priority queue unit.
// ============================================================================
package mhpq_pkg;

    // Payload widths fixed by the item format.
    localparam int KEY_W         = 32;
    localparam int CAP_LIMIT_W   = 7;
    localparam int COUNT_OUT_W   = 7;
    localparam int STATUS_W      = 2;

    // Default storage depth and reset value of the capacity limit register.
    localparam int                     CAPACITY_DEFAULT = 64;
    localparam logic [CAP_LIMIT_W-1:0] CAP_LIMIT_RESET  = 7'd64;

    // Operation codes carried in the cmd field.
    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_LAST_RD,
        ST_LAST_LD,
        ST_DN_LEFT,
        ST_DN_RIGHT,
        ST_DN_CMP,
        ST_FINISH
    } state_t;

endpackage

// File: rtl/mhpq_in_if.sv
// ============================================================================
// mhpq_in_if
// Request channel: one item is an insert or a remove-minimum command.
// ============================================================================
interface mhpq_in_if
    import mhpq_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    cmd;
    logic signed [KEY_W-1:0] key_in;

    modport source (output valid, output cmd, output key_in, input ready);
    modport sink   (input valid, input cmd, input key_in, output ready);
endinterface

// File: rtl/mhpq_out_if.sv
// ============================================================================
// mhpq_out_if
// Response channel: one item per request with status, keys and count.
// ============================================================================
interface mhpq_out_if
    import mhpq_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic signed [KEY_W-1:0] removed_key;
    logic signed [KEY_W-1:0] min_key;
    logic [COUNT_OUT_W-1:0]  entry_count;

    modport source (output valid, output status, output removed_key, output min_key,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input removed_key, input min_key,
                    input entry_count, output ready);
endinterface

// File: rtl/mhpq_ram.sv
// ============================================================================
// mhpq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port: data appears in the cycle after the read; data holds while not enabled.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/min_heap_priority_queue_unit.sv
// ============================================================================
// min_heap_priority_queue_unit
// Binary min-heap of signed 32-bit keys held in one synchronous key RAM.
// ============================================================================
// The unit takes one item at a time: an insert sifts the new key up from the
// first free slot, a remove returns the root and sifts the last key down from
// the root. Each item gives exactly one result item with status, removed key,
// new minimum and entry count. Timing is set by the single read port of the
// key RAM: an insert passes ST_UP_RD and ST_UP_CMP per parent compared, a
// remove ST_LAST_RD and ST_LAST_LD, then ST_DN_LEFT, ST_DN_RIGHT and ST_DN_CMP
// per level compared and one more ST_DN_LEFT when the key sinks to a leaf;
// refused items go straight to ST_FINISH. A finished result waits in the
// output register, and the next item is taken as soon as its result has
// moved there. The root key is also kept in a register, so the minimum is
// reported without an extra RAM read. The key RAM needs no clearing after
// reset; capacity_limit resets to 64 and is written through cfg_wr_en /
// cfg_wr_data by the user only while the unit is idle; it is not enforced.
// ============================================================================
module min_heap_priority_queue_unit
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CAP_LIMIT_W-1:0] cfg_wr_data,
    mhpq_in_if.sink                req,
    mhpq_out_if.source             rsp
);

    // Address, count and child index widths.
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;
    localparam int LW = (CW > CAP_LIMIT_W) ? CW : CAP_LIMIT_W;

    // Control registers.
    state_t                 state_reg, state_next;
    logic [CW-1:0]          count_reg;
    logic [CAP_LIMIT_W-1:0] cap_limit_reg;
    logic                   rsp_valid_reg;

    // Datapath registers.
    logic [AW-1:0]           pos_reg;
    logic signed [KEY_W-1:0] moving_reg;
    logic signed [KEY_W-1:0] left_reg;
    logic                    has_right_reg;
    logic signed [KEY_W-1:0] root_reg;
    logic signed [KEY_W-1:0] removed_reg;
    status_t                 status_reg;
    logic                    wr_final_reg;
    status_t                 rsp_status_reg;
    logic signed [KEY_W-1:0] rsp_removed_reg;
    logic signed [KEY_W-1:0] rsp_min_reg;
    logic [COUNT_OUT_W-1:0]  rsp_count_reg;

    // RAM port signals.
    logic                    ram_wr_en;
    logic [AW-1:0]           ram_wr_addr;
    logic signed [KEY_W-1:0] ram_wr_data;
    logic                    ram_rd_en;
    logic [AW-1:0]           ram_rd_addr;
    logic signed [KEY_W-1:0] ram_rd_data;

    // Handshake and decision signals.
    logic                    accept;
    logic                    out_load;
    logic                    is_remove;
    logic                    heap_full;
    logic [AW-1:0]           parent_idx;
    logic [IW-1:0]           child_idx;
    logic [IW-1:0]           right_idx;
    logic [IW-1:0]           count_ext;
    logic                    child_ok;
    logic                    right_ok;
    logic                    up_stop;
    logic signed [KEY_W-1:0] cand_key;
    logic [AW-1:0]           cand_idx;
    logic                    dn_stop;
    logic signed [KEY_W-1:0] min_now;
    logic [LW-1:0]           count_lim_ext;

    mhpq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Request decode and the full check against the effective limit.
    assign accept        = req.valid && req.ready;
    assign is_remove     = (req.cmd == CMD_REMOVE);
    assign count_lim_ext = LW'(count_reg);
    assign heap_full     = (count_lim_ext >= LW'(cap_limit_reg))
                           || (count_reg >= CW'(CAPACITY));

    // Heap index arithmetic.
    assign parent_idx = AW'(pos_reg - 1'b1) >> 1;
    assign child_idx  = IW'({pos_reg, 1'b1});
    assign right_idx  = child_idx + IW'(1);
    assign count_ext  = IW'(count_reg);
    assign child_ok   = (child_idx < count_ext);
    assign right_ok   = (right_idx < count_ext);

    // Sift comparisons; the right child wins only when strictly smaller.
    assign up_stop  = (ram_rd_data <= moving_reg);
    always_comb
    begin
        if (has_right_reg && (left_reg > ram_rd_data))
        begin
            cand_key = ram_rd_data;
            cand_idx = right_idx[AW-1:0];
        end
        else
        begin
            cand_key = left_reg;
            cand_idx = child_idx[AW-1:0];
        end
    end
    assign dn_stop = (moving_reg <= cand_key);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!is_remove)
                    begin
                        state_next = (heap_full || count_reg == '0) ? ST_FINISH : ST_UP_RD;
                    end
                    else
                    begin
                        state_next = (count_reg <= CW'(1)) ? ST_FINISH : ST_LAST_RD;
                    end
                end
            end
            ST_UP_RD:    state_next = ST_UP_CMP;
            ST_UP_CMP:
            begin
                state_next = (up_stop || parent_idx == '0) ? ST_FINISH : ST_UP_RD;
            end
            ST_LAST_RD:  state_next = ST_LAST_LD;
            ST_LAST_LD:  state_next = ST_DN_LEFT;
            ST_DN_LEFT:  state_next = child_ok ? ST_DN_RIGHT : ST_FINISH;
            ST_DN_RIGHT: state_next = ST_DN_CMP;
            ST_DN_CMP:   state_next = dn_stop ? ST_FINISH : ST_DN_LEFT;
            ST_FINISH:   state_next = out_load ? ST_IDLE : ST_FINISH;
            default:     state_next = ST_IDLE;
        endcase
    end

    // State outputs: handshake and RAM port control.
    always_comb
    begin
        req.ready   = 1'b0;
        out_load    = 1'b0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = '0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = pos_reg;
        ram_wr_data = moving_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            ST_UP_RD:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = parent_idx;
            end
            ST_UP_CMP:
            begin
                // The parent moves down into the hole.
                ram_wr_en   = !up_stop;
                ram_wr_data = ram_rd_data;
            end
            ST_LAST_RD:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = count_reg[AW-1:0];
            end
            ST_LAST_LD:
            begin
                ram_rd_en = 1'b0;
            end
            ST_DN_LEFT:
            begin
                ram_rd_en   = child_ok;
                ram_rd_addr = child_idx[AW-1:0];
            end
            ST_DN_RIGHT:
            begin
                ram_rd_en   = right_ok;
                ram_rd_addr = right_idx[AW-1:0];
            end
            ST_DN_CMP:
            begin
                // The smaller child moves up into the hole.
                ram_wr_en   = !dn_stop;
                ram_wr_data = cand_key;
            end
            ST_FINISH:
            begin
                out_load  = !rsp_valid_reg || rsp.ready;
                ram_wr_en = out_load && wr_final_reg;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    // Minimum after the item, taking a root write of this cycle into account.
    always_comb
    begin
        if (count_reg == '0)
        begin
            min_now = '0;
        end
        else if (ram_wr_en && ram_wr_addr == '0)
        begin
            min_now = ram_wr_data;
        end
        else
        begin
            min_now = root_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cap_limit_reg <= CAP_LIMIT_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                cap_limit_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                if (!is_remove && !heap_full)
                begin
                    count_reg <= count_reg + CW'(1);
                end
                else if (is_remove && count_reg != '0)
                begin
                    count_reg <= count_reg - CW'(1);
                end
            end
            if (out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            moving_reg <= req.key_in;
            if (!is_remove)
            begin
                status_reg   <= heap_full ? STATUS_FULL : STATUS_DONE;
                removed_reg  <= '0;
                wr_final_reg <= !heap_full;
                pos_reg      <= count_reg[AW-1:0];
            end
            else if (count_reg == '0)
            begin
                status_reg   <= STATUS_EMPTY;
                removed_reg  <= '0;
                wr_final_reg <= 1'b0;
                pos_reg      <= '0;
            end
            else
            begin
                status_reg   <= STATUS_DONE;
                removed_reg  <= root_reg;
                wr_final_reg <= (count_reg > CW'(1));
                pos_reg      <= '0;
            end
        end

        // Hole positions follow the sift.
        if (state_reg == ST_UP_CMP && !up_stop)
        begin
            pos_reg <= parent_idx;
        end
        if (state_reg == ST_DN_CMP && !dn_stop)
        begin
            pos_reg <= cand_idx;
        end

        // The last key becomes the key to sift down.
        if (state_reg == ST_LAST_LD)
        begin
            moving_reg <= ram_rd_data;
        end

        // Left child is kept while the right child is read.
        if (state_reg == ST_DN_RIGHT)
        begin
            left_reg      <= ram_rd_data;
            has_right_reg <= right_ok;
        end

        // Mirror of the root entry.
        if (ram_wr_en && ram_wr_addr == '0)
        begin
            root_reg <= ram_wr_data;
        end

        // Result register.
        if (out_load)
        begin
            rsp_status_reg  <= status_reg;
            rsp_removed_reg <= removed_reg;
            rsp_min_reg     <= min_now;
            rsp_count_reg   <= count_lim_ext[COUNT_OUT_W-1:0];
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.removed_key = rsp_removed_reg;
    assign rsp.min_key     = rsp_min_reg;
    assign rsp.entry_count = rsp_count_reg;

    // The entry count never passes the storage depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    // Every RAM write lands inside the held entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (CW'(ram_wr_addr) < count_reg))
        else $error("key write outside the held entries");

    // Reads never go more than one slot past the last held entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_rd_en |-> (CW'(ram_rd_addr) <= count_reg))
        else $error("key read beyond the last entry");

    // One item moves the count by at most one.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (count_reg == $past(count_reg)
                    || count_reg == $past(count_reg) + CW'(1)
                    || count_reg == $past(count_reg) - CW'(1)))
        else $error("entry count jumped by more than one");

endmodule

// File: sim/tb_min_heap_priority_queue_unit.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_min_heap_priority_queue_unit
// Self-checking bench for the min-heap priority queue unit.
// ============================================================================
// A short table of directed rows covers the empty and full refusals, the key
// extremes, equal keys and capacity limits of zero, one and two. Random
// phases follow, each under its own capacity limit, some above the storage
// depth, and insert bias, so the heap fills, drains and sees the limit
// dropped below the entry count. Every accepted item is run through a heap
// predictor; each result item is compared field by field with the oldest
// expectation. Both channel sides idle at random, with stretches of no idling.
// ============================================================================
module tb_min_heap_priority_queue_unit;
    import mhpq_pkg::*;

    localparam int HEAP_DEPTH      = CAPACITY_DEFAULT;
    localparam int DRAIN_CYCLES    = 40;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 104;
    localparam int MAX_REPORTS     = 100;

    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

    typedef enum logic {
        ROW_ITEM,
        ROW_CONFIG
    } row_kind_t;

    typedef struct {
        status_t                 status;
        logic signed [KEY_W-1:0] removed_key;
        logic signed [KEY_W-1:0] min_key;
        logic [COUNT_OUT_W-1:0]  entry_count;
    } heap_result_t;

    typedef struct {
        row_kind_t               kind;
        cmd_t                    op;
        logic signed [KEY_W-1:0] value;
        bit                      typed;
        heap_result_t            want;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CAP_LIMIT_W-1:0] cfg_wr_data;

    mhpq_in_if  req_if ();
    mhpq_out_if rsp_if ();

    min_heap_priority_queue_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_if),
        .rsp         (rsp_if)
    );

    // Predictor state: heap keys, entry count and capacity limit.
    logic signed [KEY_W-1:0] heap_keys [HEAP_DEPTH];
    int                      heap_size;
    logic [CAP_LIMIT_W-1:0]  heap_limit;

    heap_result_t pending_results[$];
    int           fail_count;
    int           result_count;
    int           send_burst;
    int           recv_burst;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard limit on run time in case the unit hangs.
    initial
    begin
        #1_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Prints one line per mismatch, up to a cap, and counts every one.
    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: %s", $time, msg);
    endtask

    // Applies one item to the predicted heap and returns its result item.
    function automatic heap_result_t apply_heap_op(input cmd_t op,
                                                   input logic signed [KEY_W-1:0] key);
        heap_result_t            res;
        int                      limit;
        int                      pos;
        int                      parent;
        int                      child;
        logic signed [KEY_W-1:0] moving;

        res.status      = STATUS_DONE;
        res.removed_key = '0;
        limit = (heap_limit < HEAP_DEPTH) ? int'(heap_limit) : HEAP_DEPTH;

        if (op == CMD_INSERT)
        begin
            if (heap_size >= limit)
                res.status = STATUS_FULL;
            else
            begin
                // Sift up: stop at a parent that is not larger than the key.
                pos = heap_size;
                while (pos > 0)
                begin
                    parent = (pos - 1) / 2;
                    if (heap_keys[parent] <= key)
                        break;
                    heap_keys[pos] = heap_keys[parent];
                    pos = parent;
                end
                heap_keys[pos] = key;
                heap_size++;
            end
        end
        else if (heap_size == 0)
            res.status = STATUS_EMPTY;
        else
        begin
            // Take the root, then sift the last key down from the root.
            res.removed_key = heap_keys[0];
            heap_size--;
            moving = heap_keys[heap_size];
            pos    = 0;
            child  = 1;
            while (child < heap_size)
            begin
                if (child + 1 < heap_size && heap_keys[child] > heap_keys[child + 1])
                    child++;
                if (moving <= heap_keys[child])
                    break;
                heap_keys[pos] = heap_keys[child];
                pos   = child;
                child = 2 * pos + 1;
            end
            if (heap_size > 0)
                heap_keys[pos] = moving;
        end

        res.min_key     = (heap_size > 0) ? heap_keys[0] : '0;
        res.entry_count = heap_size[COUNT_OUT_W-1:0];
        return res;
    endfunction

    // Wait length for one item, with occasional runs of back-to-back items.
    function automatic int draw_wait(inout int burst_left);
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            burst_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 15);
    endfunction

    // Keys mix extremes, a narrow band that forces ties, and full-range values.
    function automatic logic signed [KEY_W-1:0] draw_key();
        int pick;
        int band;

        pick = $urandom_range(0, 9);
        band = $urandom_range(0, 8);
        case (pick)
            0:       return KEY_MIN;
            1:       return KEY_MAX;
            2, 3, 4: return band - 4;
            default: return $urandom;
        endcase
    endfunction

    function automatic stim_row_t item_row(input cmd_t op,
                                           input logic signed [KEY_W-1:0] key);
        stim_row_t row;

        row.kind                  = ROW_ITEM;
        row.op                    = op;
        row.value                 = key;
        row.typed                 = 1'b0;
        row.want.status           = STATUS_DONE;
        row.want.removed_key      = '0;
        row.want.min_key          = '0;
        row.want.entry_count      = '0;
        return row;
    endfunction

    function automatic stim_row_t checked_row(input cmd_t op,
                                              input logic signed [KEY_W-1:0] key,
                                              input status_t status,
                                              input logic signed [KEY_W-1:0] removed,
                                              input logic signed [KEY_W-1:0] min_key,
                                              input int count);
        stim_row_t row;

        row                  = item_row(op, key);
        row.typed            = 1'b1;
        row.want.status      = status;
        row.want.removed_key = removed;
        row.want.min_key     = min_key;
        row.want.entry_count = count[COUNT_OUT_W-1:0];
        return row;
    endfunction

    function automatic stim_row_t config_row(input int limit);
        stim_row_t row;

        row       = item_row(CMD_INSERT, '0);
        row.kind  = ROW_CONFIG;
        row.value = limit;
        return row;
    endfunction

    // Offers one item, waits for acceptance, then records what must come back.
    task automatic send_item(input cmd_t op, input logic signed [KEY_W-1:0] key,
                             input bit typed, input heap_result_t want);
        int           gap;
        heap_result_t predicted;

        gap = draw_wait(send_burst);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid  <= 1'b1;
        req_if.cmd    <= op;
        req_if.key_in <= key;
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);

        predicted = apply_heap_op(op, key);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Writes the capacity limit once every outstanding result has returned.
    task automatic write_capacity_limit(input logic [CAP_LIMIT_W-1:0] value);
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        heap_limit  = value;
    endtask

    // Result side: random stalls, then a field-by-field check of each item.
    initial
    begin
        int           stall;
        heap_result_t want;

        rsp_if.ready <= 1'b0;
        recv_burst    = 0;
        result_count  = 0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);

        forever
        begin
            stall = draw_wait(recv_burst);
            if (stall > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (rsp_if.valid !== 1'b1);

            result_count++;
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result %0d arrived with no item outstanding",
                                          result_count));
            else
            begin
                want = pending_results.pop_front();
                if (rsp_if.status !== want.status)
                    report_mismatch($sformatf("result %0d status: got %0d, expected %0d",
                                              result_count, rsp_if.status, want.status));
                if (rsp_if.removed_key !== want.removed_key)
                    report_mismatch($sformatf("result %0d removed_key: got %0d, expected %0d",
                                              result_count, rsp_if.removed_key,
                                              want.removed_key));
                if (rsp_if.min_key !== want.min_key)
                    report_mismatch($sformatf("result %0d min_key: got %0d, expected %0d",
                                              result_count, rsp_if.min_key, want.min_key));
                if (rsp_if.entry_count !== want.entry_count)
                    report_mismatch($sformatf("result %0d entry_count: got %0d, expected %0d",
                                              result_count, rsp_if.entry_count,
                                              want.entry_count));
            end
        end
    end

    // Stimulus: reset, directed table, random phases, then drain and verdict.
    initial
    begin
        stim_row_t              directed_rows[$];
        stim_row_t              row;
        logic [CAP_LIMIT_W-1:0] limit;
        int                     insert_pct;
        cmd_t                   op;

        rst_n          <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_wr_data    <= '0;
        req_if.valid   <= 1'b0;
        req_if.cmd     <= CMD_INSERT;
        req_if.key_in  <= '0;
        heap_size       = 0;
        heap_limit      = CAP_LIMIT_RESET;
        fail_count      = 0;
        send_burst      = 0;

        // Empty heap after reset, then key extremes and ties.
        directed_rows.push_back(checked_row(CMD_REMOVE, 0, STATUS_EMPTY, 0, 0, 0));
        directed_rows.push_back(checked_row(CMD_INSERT, KEY_MAX, STATUS_DONE, 0, KEY_MAX, 1));
        directed_rows.push_back(checked_row(CMD_INSERT, KEY_MIN, STATUS_DONE, 0, KEY_MIN, 2));
        directed_rows.push_back(checked_row(CMD_INSERT, 0, STATUS_DONE, 0, KEY_MIN, 3));
        directed_rows.push_back(checked_row(CMD_INSERT, -1, STATUS_DONE, 0, KEY_MIN, 4));
        directed_rows.push_back(item_row(CMD_INSERT, 5));
        directed_rows.push_back(item_row(CMD_INSERT, 5));
        directed_rows.push_back(item_row(CMD_INSERT, -1));
        directed_rows.push_back(checked_row(CMD_REMOVE, KEY_MAX, STATUS_DONE, KEY_MIN, -1, 6));
        repeat (6)
            directed_rows.push_back(item_row(CMD_REMOVE, $urandom));
        directed_rows.push_back(checked_row(CMD_REMOVE, 0, STATUS_EMPTY, 0, 0, 0));

        // A zero limit refuses every insert.
        directed_rows.push_back(config_row(0));
        directed_rows.push_back(checked_row(CMD_INSERT, 7, STATUS_FULL, 0, 0, 0));

        // A limit of two fills after two inserts.
        directed_rows.push_back(config_row(2));
        directed_rows.push_back(item_row(CMD_INSERT, 3));
        directed_rows.push_back(item_row(CMD_INSERT, 9));
        directed_rows.push_back(checked_row(CMD_INSERT, 1, STATUS_FULL, 0, 3, 2));

        // Limit lowered below the count: inserts refused, removes still work.
        directed_rows.push_back(config_row(1));
        directed_rows.push_back(checked_row(CMD_INSERT, 4, STATUS_FULL, 0, 3, 2));
        directed_rows.push_back(checked_row(CMD_REMOVE, 0, STATUS_DONE, 3, 9, 1));
        directed_rows.push_back(checked_row(CMD_INSERT, 4, STATUS_FULL, 0, 9, 1));
        directed_rows.push_back(checked_row(CMD_REMOVE, 0, STATUS_DONE, 9, 0, 0));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_CONFIG)
                write_capacity_limit(row.value[CAP_LIMIT_W-1:0]);
            else
                send_item(row.op, row.value, row.typed, row.want);
        end

        // Random phases, each under its own limit and insert bias.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       limit = 7'd64;
                1:       limit = 7'd1;
                2:       limit = 7'd127;
                3:       limit = CAP_LIMIT_W'($urandom_range(2, 63));
                4:       limit = CAP_LIMIT_W'($urandom_range(65, 126));
                5:       limit = 7'd0;
                6:       limit = CAP_LIMIT_W'($urandom_range(0, 127));
                default: limit = 7'd64;
            endcase
            insert_pct = (phase == 2) ? 90 : $urandom_range(30, 80);
            write_capacity_limit(limit);

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 99) < insert_pct)
                    op = CMD_INSERT;
                else
                    op = CMD_REMOVE;
                send_item(op, draw_key(), 1'b0, row.want);
            end
        end

        // Drain outstanding results, then allow a few idle cycles.
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
